>>> rtl/core/assert_macros.svh
// Assertion macros shared by the waypoint wheel speed controller RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/wwsc_pkg.sv
// Package of the waypoint wheel speed controller: types, constants, arctangent table.
// Depends on nothing; used by the controller top, the registers, the sequencer and the datapath.
`default_nettype none

package wwsc_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_LEN = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
   localparam int STEP_W = $clog2(ATAN_LEN);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_ITERS - 1);

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SPEED_LIMIT,
      REG_NEAR_RADIUS,
      REG_NEAR_GAIN,
      REG_NEAR_CAP,
      REG_FAR_FRACTION,
      REG_HEADING_BLEND,
      REG_TURN_GAIN
   } csr_reg_type;

   // Angles are Q.29 radians, carried in 34 or 36 bits.
   localparam logic signed [35:0] PI_Q29 = 36'sd1686629713;
   localparam logic signed [35:0] TWO_PI_Q29 = 36'sd3373259426;
   localparam logic signed [33:0] HALF_PI_Q29 = 34'sd843314857;
   localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [30:0] INV_GAIN_MUL = 31'sd652032874;
   localparam logic signed [30:0] INV_PI_Q30 = 31'sd341782638;
   localparam logic signed [25:0] OFFSET_LIMIT = 26'sd32767;

   typedef enum logic [4:0] {
      OP_NOP,
      OP_ROT_INIT,
      OP_ROT_STEP,
      OP_ROT_END,
      OP_PROJ1,
      OP_PROJ2,
      OP_PROJ3,
      OP_VEC_INIT,
      OP_VEC_STEP,
      OP_MAG,
      OP_DIST,
      OP_SPD1,
      OP_SPD2,
      OP_SPD3,
      OP_BL1,
      OP_BL2,
      OP_BL3,
      OP_WRAP,
      OP_RAT1,
      OP_RAT2,
      OP_TRN1,
      OP_TRN2,
      OP_TRN3,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic [STEP_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic wrap_ok;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic [9:0] speed_limit;
      logic [15:0] near_radius;
      logic [7:0] near_gain;
      logic [9:0] near_speed_cap;
      logic [8:0] far_fraction;
      logic [8:0] heading_blend;
      logic [9:0] turn_gain;
   } cfg_type;

   function automatic logic signed [33:0] atan_q29(input logic [STEP_W-1:0] i);
      logic signed [33:0] v;
      unique case (i)
         5'd0: v = 34'sd421657428;
         5'd1: v = 34'sd248918915;
         5'd2: v = 34'sd131521918;
         5'd3: v = 34'sd66762579;
         5'd4: v = 34'sd33510843;
         5'd5: v = 34'sd16771758;
         5'd6: v = 34'sd8387925;
         5'd7: v = 34'sd4194219;
         5'd8: v = 34'sd2097141;
         5'd9: v = 34'sd1048575;
         5'd10: v = 34'sd524288;
         5'd11: v = 34'sd262144;
         5'd12: v = 34'sd131072;
         5'd13: v = 34'sd65536;
         5'd14: v = 34'sd32768;
         5'd15: v = 34'sd16384;
         5'd16: v = 34'sd8192;
         5'd17: v = 34'sd4096;
         5'd18: v = 34'sd2048;
         5'd19: v = 34'sd1024;
         5'd20: v = 34'sd512;
         5'd21: v = 34'sd256;
         5'd22: v = 34'sd128;
         5'd23: v = 34'sd64;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/wwsc_ifs.sv
// Valid/ready channel interfaces for the pose request and the wheel command response.
// Depends on nothing.
`default_nettype none

interface wwsc_req_if;
   logic valid;
   logic ready;
   logic signed [15:0] wp_x;
   logic signed [15:0] wp_y;
   logic signed [15:0] wp_heading;
   logic signed [15:0] robot_x;
   logic signed [15:0] robot_y;
   logic signed [15:0] robot_heading;
   modport source (output valid, wp_x, wp_y, wp_heading, robot_x, robot_y, robot_heading,
                   input ready);
   modport sink (input valid, wp_x, wp_y, wp_heading, robot_x, robot_y, robot_heading,
                 output ready);
endinterface

interface wwsc_rsp_if;
   logic valid;
   logic ready;
   logic [15:0] left_cmd;
   logic [15:0] right_cmd;
   modport source (output valid, left_cmd, right_cmd, input ready);
   modport sink (input valid, left_cmd, right_cmd, output ready);
endinterface

`default_nettype wire

>>> rtl/core/waypoint_wheel_speed_controller_top.sv
// Requests are worked one at a time, by the two 16-step passes of the single shared
// CORDIC unit and the one shared multiplier. A held response lets the next request in;
// that item stalls before output until it is taken.
// Reset is synchronous, active high: the configuration registers return to defaults,
// the sequencer goes idle, the projection history and the approach offset clear to zero,
// and no response is pending.
`default_nettype none

module waypoint_wheel_speed_controller_top (
   input  wire logic clock,
   input  wire logic reset,
   wwsc_req_if.sink req_ch,
   wwsc_rsp_if.source rsp_ch,
   input  wire logic csr_we,
   input  wire logic [wwsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wwsc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   wwsc_pkg::cfg_type cfg;
   wwsc_pkg::cmd_type cmd;
   wwsc_pkg::status_type status;
   logic req_ready;
   logic accept;

   // A request transfer happens only while the sequencer is idle; the datapath
   // captures the pose differences on that edge.
   assign req_ch.ready = req_ready;
   assign accept = req_ch.valid && req_ready;

   wwsc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   // The sequencer walks through rotation CORDIC (sin and cos of the waypoint
   // heading), the projection, vectoring CORDIC (distance and bearing), the speed
   // law, the heading blend and wrap, and the turn term.
   wwsc_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   wwsc_dpath u_dpath (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .wp_x(req_ch.wp_x),
      .wp_y(req_ch.wp_y),
      .wp_heading(req_ch.wp_heading),
      .robot_x(req_ch.robot_x),
      .robot_y(req_ch.robot_y),
      .robot_heading(req_ch.robot_heading),
      .cfg(cfg),
      .cmd(cmd),
      .status(status),
      .rsp_ready(rsp_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .left_cmd(rsp_ch.left_cmd),
      .right_cmd(rsp_ch.right_cmd)
   );

endmodule

`default_nettype wire

>>> rtl/core/wwsc_csr.sv
// Configuration registers of the waypoint wheel speed controller.
// Depends on wwsc_pkg.
`default_nettype none

module wwsc_csr (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_we,
   input  wire logic [wwsc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [wwsc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output wwsc_pkg::cfg_type cfg
);

   wwsc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_limit <= 10'd300;
         cfg_ff.near_radius <= 16'd256;
         cfg_ff.near_gain <= 8'd20;
         cfg_ff.near_speed_cap <= 10'd100;
         cfg_ff.far_fraction <= 9'd230;
         cfg_ff.heading_blend <= 9'd26;
         cfg_ff.turn_gain <= 10'd461;
      end else if (csr_we) begin
         unique case (csr_index)
            wwsc_pkg::REG_SPEED_LIMIT: cfg_ff.speed_limit <= csr_wdata[9:0];
            wwsc_pkg::REG_NEAR_RADIUS: cfg_ff.near_radius <= csr_wdata;
            wwsc_pkg::REG_NEAR_GAIN: cfg_ff.near_gain <= csr_wdata[7:0];
            wwsc_pkg::REG_NEAR_CAP: cfg_ff.near_speed_cap <= csr_wdata[9:0];
            wwsc_pkg::REG_FAR_FRACTION: cfg_ff.far_fraction <= csr_wdata[8:0];
            wwsc_pkg::REG_HEADING_BLEND: cfg_ff.heading_blend <= csr_wdata[8:0];
            wwsc_pkg::REG_TURN_GAIN: cfg_ff.turn_gain <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/wwsc_ctrl.sv
// Sequencer of the waypoint wheel speed controller: issues one datapath command per cycle.
// Depends on wwsc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wwsc_ctrl (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic req_ready,
   input  wwsc_pkg::status_type status,
   output wwsc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_BUSY,
      ST_FINISH
   } state_type;

   state_type state_ff;
   wwsc_pkg::cmd_type cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff.op <= wwsc_pkg::OP_NOP;
         cmd_ff.idx <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               cmd_ff.idx <= '0;
               if (req_valid) begin
                  state_ff <= ST_BUSY;
                  cmd_ff.op <= wwsc_pkg::OP_ROT_INIT;
               end else begin
                  cmd_ff.op <= wwsc_pkg::OP_NOP;
               end
            end
            ST_BUSY: begin
               unique case (cmd_ff.op)
                  wwsc_pkg::OP_ROT_INIT: begin
                     cmd_ff.op <= wwsc_pkg::OP_ROT_STEP;
                     cmd_ff.idx <= '0;
                  end
                  wwsc_pkg::OP_ROT_STEP: begin
                     if (cmd_ff.idx == wwsc_pkg::LAST_STEP) begin
                        cmd_ff.op <= wwsc_pkg::OP_ROT_END;
                     end else begin
                        cmd_ff.idx <= cmd_ff.idx + 1'b1;
                     end
                  end
                  wwsc_pkg::OP_ROT_END: cmd_ff.op <= wwsc_pkg::OP_PROJ1;
                  wwsc_pkg::OP_PROJ1: cmd_ff.op <= wwsc_pkg::OP_PROJ2;
                  wwsc_pkg::OP_PROJ2: cmd_ff.op <= wwsc_pkg::OP_PROJ3;
                  wwsc_pkg::OP_PROJ3: cmd_ff.op <= wwsc_pkg::OP_VEC_INIT;
                  wwsc_pkg::OP_VEC_INIT: begin
                     cmd_ff.op <= wwsc_pkg::OP_VEC_STEP;
                     cmd_ff.idx <= '0;
                  end
                  wwsc_pkg::OP_VEC_STEP: begin
                     if (cmd_ff.idx == wwsc_pkg::LAST_STEP) begin
                        cmd_ff.op <= wwsc_pkg::OP_MAG;
                     end else begin
                        cmd_ff.idx <= cmd_ff.idx + 1'b1;
                     end
                  end
                  wwsc_pkg::OP_MAG: cmd_ff.op <= wwsc_pkg::OP_DIST;
                  wwsc_pkg::OP_DIST: cmd_ff.op <= wwsc_pkg::OP_SPD1;
                  wwsc_pkg::OP_SPD1: cmd_ff.op <= wwsc_pkg::OP_SPD2;
                  wwsc_pkg::OP_SPD2: cmd_ff.op <= wwsc_pkg::OP_SPD3;
                  wwsc_pkg::OP_SPD3: cmd_ff.op <= wwsc_pkg::OP_BL1;
                  wwsc_pkg::OP_BL1: cmd_ff.op <= wwsc_pkg::OP_BL2;
                  wwsc_pkg::OP_BL2: cmd_ff.op <= wwsc_pkg::OP_BL3;
                  wwsc_pkg::OP_BL3: cmd_ff.op <= wwsc_pkg::OP_WRAP;
                  wwsc_pkg::OP_WRAP: begin
                     // Keep folding by a full turn until the error lies in [-pi, pi).
                     if (status.wrap_ok) begin
                        cmd_ff.op <= wwsc_pkg::OP_RAT1;
                     end
                  end
                  wwsc_pkg::OP_RAT1: cmd_ff.op <= wwsc_pkg::OP_RAT2;
                  wwsc_pkg::OP_RAT2: cmd_ff.op <= wwsc_pkg::OP_TRN1;
                  wwsc_pkg::OP_TRN1: cmd_ff.op <= wwsc_pkg::OP_TRN2;
                  wwsc_pkg::OP_TRN2: cmd_ff.op <= wwsc_pkg::OP_TRN3;
                  wwsc_pkg::OP_TRN3: begin
                     cmd_ff.op <= wwsc_pkg::OP_NOP;
                     state_ff <= ST_FINISH;
                  end
                  default: begin
                     cmd_ff.op <= wwsc_pkg::OP_NOP;
                     state_ff <= ST_IDLE;
                  end
               endcase
            end
            ST_FINISH: begin
               // The output register is free by the next cycle once it is seen not busy.
               if (!status.out_busy) begin
                  cmd_ff.op <= wwsc_pkg::OP_OUT;
                  state_ff <= ST_IDLE;
               end else begin
                  cmd_ff.op <= wwsc_pkg::OP_NOP;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               cmd_ff.op <= wwsc_pkg::OP_NOP;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign cmd = cmd_ff;

   `ASSERT_NEXT(a_accept_starts, clock, reset, req_valid && req_ready, cmd_ff.op == wwsc_pkg::OP_ROT_INIT, "accepted transfer did not start the rotation")
   `ASSERT_SAME(a_step_bound, clock, reset, cmd_ff.op == wwsc_pkg::OP_ROT_STEP || cmd_ff.op == wwsc_pkg::OP_VEC_STEP, cmd_ff.idx <= wwsc_pkg::LAST_STEP, "CORDIC step index past the last step")

endmodule

`default_nettype wire

>>> rtl/core/wwsc_dpath.sv
// Datapath of the waypoint wheel speed controller: shared CORDIC, one multiplier, state.
// Depends on wwsc_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module wwsc_dpath (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire logic signed [15:0] wp_x,
   input  wire logic signed [15:0] wp_y,
   input  wire logic signed [15:0] wp_heading,
   input  wire logic signed [15:0] robot_x,
   input  wire logic signed [15:0] robot_y,
   input  wire logic signed [15:0] robot_heading,
   input  wwsc_pkg::cfg_type cfg,
   input  wwsc_pkg::cmd_type cmd,
   output wwsc_pkg::status_type status,
   input  wire logic rsp_ready,
   output logic rsp_valid,
   output logic [15:0] left_cmd,
   output logic [15:0] right_cmd
);

   logic signed [16:0] dx_ff, dy_ff;
   logic signed [31:0] wph_ff, rbh_ff;
   logic signed [33:0] x_ff, y_ff, z_ff, c_ff, s_ff, bear_ff;
   logic flip_ff, far_ff;
   logic signed [64:0] p_ff, t_ff;
   logic signed [23:0] proj_ff, prev_ff, ao_ff;
   logic [17:0] dist_ff;
   logic [15:0] prop_ff, speed_ff;
   logic signed [35:0] err_ff;
   logic signed [16:0] ratio_ff;
   logic signed [19:0] turn_ff;
   logic rsp_valid_ff;
   logic [15:0] left_ff, right_ff;

   logic signed [33:0] mul_a;
   logic signed [30:0] mul_b;
   logic signed [64:0] prod;
   logic signed [33:0] xs, ys, atan_v;
   logic rot_pos;
   logic [8:0] ff_eff, hb_eff;
   logic far_now;
   logic [15:0] top;
   logic signed [64:0] q_spd, sum_pt;
   logic signed [25:0] ao_sum, ao_new;
   logic signed [18:0] raw_speed;
   logic signed [20:0] left_raw, right_raw;
   logic signed [33:0] vx, vy;
   logic err_hi, err_lo;

   assign ff_eff = (cfg.far_fraction > 9'd256) ? 9'd256 : cfg.far_fraction;
   assign hb_eff = (cfg.heading_blend > 9'd256) ? 9'd256 : cfg.heading_blend;
   assign far_now = dist_ff > {2'b00, cfg.near_radius};
   assign top = {cfg.speed_limit, 6'b0};
   assign err_hi = err_ff >= wwsc_pkg::PI_Q29;
   assign err_lo = err_ff < -wwsc_pkg::PI_Q29;

   // CORDIC micro-rotation shared by rotation and vectoring modes.
   assign xs = x_ff >>> cmd.idx;
   assign ys = y_ff >>> cmd.idx;
   assign atan_v = wwsc_pkg::atan_q29(cmd.idx);
   assign rot_pos = (cmd.op == wwsc_pkg::OP_ROT_STEP) ? !z_ff[33] : y_ff[33];

   assign vx = 34'(dx_ff) <<< 12;
   assign vy = 34'(dy_ff) <<< 12;

   assign sum_pt = p_ff + t_ff;
   assign q_spd = p_ff >>> 2;
   assign ao_sum = 26'(ao_ff) + 26'(proj_ff) - 26'(prev_ff);
   assign ao_new = (ao_sum > wwsc_pkg::OFFSET_LIMIT) ? wwsc_pkg::OFFSET_LIMIT :
                   (ao_sum < -wwsc_pkg::OFFSET_LIMIT) ? -wwsc_pkg::OFFSET_LIMIT : ao_sum;
   assign raw_speed = $signed({3'b000, prop_ff}) + (far_ff ? 19'sd0 : 19'(ao_ff >>> 2));
   assign left_raw = $signed({5'b0, speed_ff}) - 21'(turn_ff);
   assign right_raw = $signed({5'b0, speed_ff}) + 21'(turn_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         wwsc_pkg::OP_PROJ1: begin
            mul_a = c_ff;
            mul_b = 31'(dx_ff);
         end
         wwsc_pkg::OP_PROJ2: begin
            mul_a = s_ff;
            mul_b = 31'(dy_ff);
         end
         wwsc_pkg::OP_MAG: begin
            mul_a = x_ff;
            mul_b = wwsc_pkg::INV_GAIN_MUL;
         end
         wwsc_pkg::OP_SPD1: begin
            mul_a = far_now ? $signed(34'(cfg.speed_limit)) : $signed(34'(dist_ff));
            mul_b = far_now ? $signed(31'(ff_eff)) : $signed(31'(cfg.near_gain));
         end
         wwsc_pkg::OP_BL1: begin
            mul_a = 34'(wph_ff);
            mul_b = $signed(31'(hb_eff));
         end
         wwsc_pkg::OP_BL2: begin
            mul_a = bear_ff;
            mul_b = $signed(31'(9'd256 - hb_eff));
         end
         wwsc_pkg::OP_RAT1: begin
            mul_a = err_ff[33:0];
            mul_b = wwsc_pkg::INV_PI_Q30;
         end
         wwsc_pkg::OP_TRN1: begin
            mul_a = 34'(ratio_ff);
            mul_b = $signed(31'(speed_ff));
         end
         wwsc_pkg::OP_TRN2: begin
            mul_a = p_ff[33:0];
            mul_b = $signed(31'(cfg.turn_gain));
         end
         default: ;
      endcase
   end

   assign prod = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (accept) begin
         dx_ff <= 17'(wp_x) - 17'(robot_x);
         dy_ff <= 17'(wp_y) - 17'(robot_y);
         wph_ff <= {wp_heading, 16'b0};
         rbh_ff <= {robot_heading, 16'b0};
      end
      unique case (cmd.op)
         wwsc_pkg::OP_ROT_INIT: begin
            x_ff <= wwsc_pkg::INV_GAIN_Q30;
            y_ff <= '0;
            // Fold the angle into [-pi/2, pi/2]; the results are negated at the end.
            if (34'(wph_ff) > wwsc_pkg::HALF_PI_Q29) begin
               z_ff <= 34'(wph_ff) - 34'(wwsc_pkg::PI_Q29);
               flip_ff <= 1'b1;
            end else if (34'(wph_ff) < -wwsc_pkg::HALF_PI_Q29) begin
               z_ff <= 34'(wph_ff) + 34'(wwsc_pkg::PI_Q29);
               flip_ff <= 1'b1;
            end else begin
               z_ff <= 34'(wph_ff);
               flip_ff <= 1'b0;
            end
         end
         wwsc_pkg::OP_ROT_STEP, wwsc_pkg::OP_VEC_STEP: begin
            if (rot_pos) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_v;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_v;
            end
         end
         wwsc_pkg::OP_ROT_END: begin
            c_ff <= flip_ff ? -x_ff : x_ff;
            s_ff <= flip_ff ? -y_ff : y_ff;
         end
         wwsc_pkg::OP_PROJ1, wwsc_pkg::OP_MAG, wwsc_pkg::OP_BL1, wwsc_pkg::OP_RAT1,
         wwsc_pkg::OP_TRN1, wwsc_pkg::OP_TRN2: begin
            p_ff <= prod;
         end
         wwsc_pkg::OP_PROJ2, wwsc_pkg::OP_BL2: begin
            t_ff <= prod;
         end
         wwsc_pkg::OP_PROJ3: begin
            proj_ff <= 24'((sum_pt + (65'sd1 <<< 29)) >>> 30);
         end
         wwsc_pkg::OP_VEC_INIT: begin
            // Left half plane: turn the vector by pi and start the angle there.
            if (dx_ff < 0) begin
               x_ff <= -vx;
               y_ff <= -vy;
               z_ff <= (dy_ff >= 0) ? 34'(wwsc_pkg::PI_Q29) : -34'(wwsc_pkg::PI_Q29);
            end else begin
               x_ff <= vx;
               y_ff <= vy;
               z_ff <= '0;
            end
         end
         wwsc_pkg::OP_DIST: begin
            dist_ff <= 18'((p_ff + (65'sd1 <<< 41)) >>> 42);
            bear_ff <= z_ff;
         end
         wwsc_pkg::OP_SPD1: begin
            p_ff <= prod;
            far_ff <= far_now;
         end
         wwsc_pkg::OP_SPD2: begin
            if (far_ff) begin
               prop_ff <= q_spd[15:0];
            end else begin
               prop_ff <= (q_spd > 65'({cfg.near_speed_cap, 6'b0})) ?
                          {cfg.near_speed_cap, 6'b0} : q_spd[15:0];
            end
         end
         wwsc_pkg::OP_SPD3: begin
            if (raw_speed < 0) begin
               speed_ff <= '0;
            end else if (raw_speed > $signed({3'b000, top})) begin
               speed_ff <= top;
            end else begin
               speed_ff <= raw_speed[15:0];
            end
         end
         wwsc_pkg::OP_BL3: begin
            err_ff <= 36'(sum_pt >>> 8) - 36'(rbh_ff);
         end
         wwsc_pkg::OP_WRAP: begin
            if (err_hi) begin
               err_ff <= err_ff - wwsc_pkg::TWO_PI_Q29;
            end else if (err_lo) begin
               err_ff <= err_ff + wwsc_pkg::TWO_PI_Q29;
            end
         end
         wwsc_pkg::OP_RAT2: begin
            ratio_ff <= 17'((p_ff + (65'sd1 <<< 43)) >>> 44);
         end
         wwsc_pkg::OP_TRN3: begin
            turn_ff <= 20'(p_ff >>> 23);
         end
         wwsc_pkg::OP_OUT: begin
            left_ff <= (left_raw < 0) ? 16'd0 :
                       (left_raw > $signed({5'b0, top})) ? top : left_raw[15:0];
            right_ff <= (right_raw < 0) ? 16'd0 :
                        (right_raw > $signed({5'b0, top})) ? top : right_raw[15:0];
         end
         default: ;
      endcase
      if (reset) begin
         prev_ff <= '0;
         ao_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.op == wwsc_pkg::OP_SPD2) begin
            prev_ff <= proj_ff;
            // The offset sum moves only on near ticks.
            if (!far_ff) begin
               ao_ff <= 24'(ao_new);
            end
         end
         if (cmd.op == wwsc_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.wrap_ok = !err_hi && !err_lo;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign left_cmd = left_ff;
   assign right_cmd = right_ff;

   `ASSERT_SAME(a_ratio_wrapped, clock, reset, cmd.op == wwsc_pkg::OP_RAT1, !err_hi && !err_lo, "heading error used before it was wrapped")
   `ASSERT_SAME(a_out_free, clock, reset, cmd.op == wwsc_pkg::OP_OUT, !rsp_valid_ff, "result written over an untaken result")

endmodule

`default_nettype wire
